>>> sv/apts_pkg.sv
// Package for the age-priority task scheduler: payload structs, register
// indexes and shared constants. No dependencies.
package apts_pkg;

   localparam int NumSlotsDefault   = 4;
   localparam int CyclesPerUsDefault = 100;
   localparam int EstShiftDefault   = 7;

   localparam int NumRegs     = 8;
   localparam int RegIdxWidth = 3;
   localparam int SignalSlot  = 1;

   localparam logic [RegIdxWidth-1:0] REG_PERIOD0   = 3'd0;
   localparam logic [RegIdxWidth-1:0] REG_PERIOD1   = 3'd1;
   localparam logic [RegIdxWidth-1:0] REG_PERIOD2   = 3'd2;
   localparam logic [RegIdxWidth-1:0] REG_PERIOD3   = 3'd3;
   localparam logic [RegIdxWidth-1:0] REG_GUARD_MIN = 3'd4;
   localparam logic [RegIdxWidth-1:0] REG_GUARD_MAX = 3'd5;
   localparam logic [RegIdxWidth-1:0] REG_GUARD_UP  = 3'd6;
   localparam logic [RegIdxWidth-1:0] REG_GUARD_DN  = 3'd7;

   localparam logic KIND_SCHEDULE   = 1'b0;
   localparam logic KIND_COMPLETION = 1'b1;

   localparam logic [15:0] AgeMax = 16'd65534;

   typedef struct packed {
      logic        kind;
      logic [31:0] now_us;
      logic [31:0] cycles_to_deadline;
      logic        rx_ready;
      logic [23:0] exec_time_us;
      logic [31:0] overrun_cycles;
   } req_type;

   typedef struct packed {
      logic [1:0]  selected_slot;
      logic        slot_selected;
      logic        run_granted;
      logic        expedited;
      logic [15:0] guard_margin_cycles;
      logic [23:0] estimate_us;
   } rsp_type;

   typedef struct packed {
      logic [19:0] period0;
      logic [19:0] period1;
      logic [19:0] period2;
      logic [19:0] period3;
      logic [15:0] guard_min;
      logic [15:0] guard_max;
      logic [15:0] guard_up;
      logic [15:0] guard_down;
   } cfg_type;

endpackage

>>> sv/apts_front.sv
// Front end: accepts request words, clears the fields their kind does not use,
// and holds them in a two-entry queue toward the back end. Depends on apts_pkg.
module apts_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  apts_pkg::req_type req_data,
   output logic              q_valid,
   input  logic              q_take,
   output apts_pkg::req_type q_data
);
   import apts_pkg::*;

   req_type     mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;
   req_type     clean;

   // Fields that the item kind does not use are zeroed here.
   always_comb begin
      clean = req_data;
      if (req_data.kind == KIND_COMPLETION) begin
         clean.now_us             = '0;
         clean.cycles_to_deadline = '0;
         clean.rx_ready           = 1'b0;
      end else begin
         clean.exec_time_us   = '0;
         clean.overrun_cycles = '0;
      end
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_take ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= clean;
      end
   end
endmodule

>>> sv/apts_div.sv
// Serial restoring divider: 32-bit dividend by 20-bit divisor, one quotient
// bit per cycle. No dependencies.
module apts_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [19:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [31:0] quo_ff, quo_in;
   logic [20:0] rem_ff, rem_in;
   logic [19:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [20:0] trial;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[19:0], quo_ff[31]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end
endmodule

>>> sv/apts_back.sv
// Back end: ages the slots one at a time through a shared divider, picks
// and grants, updates estimates and the guard. Depends on apts_pkg, apts_div.
module apts_back #(
   parameter int NUM_SLOTS     = apts_pkg::NumSlotsDefault,
   parameter int CYCLES_PER_US = apts_pkg::CyclesPerUsDefault,
   parameter int EST_SHIFT     = apts_pkg::EstShiftDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  apts_pkg::cfg_type cfg,
   input  logic              q_valid,
   output logic              q_take,
   input  apts_pkg::req_type q_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output apts_pkg::rsp_type rsp_data,
   output logic [15:0]       guard_now
);
   import apts_pkg::*;

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [SW-1:0] LastSlot = SW'(NUM_SLOTS - 1);
   localparam logic [SW-1:0] SigSlot  = SW'(SignalSlot);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_AGE    = 3'd1;
   localparam logic [2:0] ST_WAIT   = 3'd2;
   localparam logic [2:0] ST_NEED   = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_CUT    = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0]    st_ff, st_in;
   logic [SW-1:0] k_ff, k_in;
   req_type       it_ff, it_in;

   logic [31:0] last_run_ff [NUM_SLOTS];
   logic [15:0] prio_ff     [NUM_SLOTS];
   logic [15:0] age_ff      [NUM_SLOTS];
   logic [31:0] est_ff      [NUM_SLOTS];
   logic [31:0] last_sig_ff, last_sig_in;
   logic [15:0] guard_ff, guard_in;
   logic [SW-1:0] pend_ff, pend_in;

   logic          wr_slot;
   logic [SW-1:0] wr_idx;
   logic [31:0]   wr_last_run;
   logic [15:0]   wr_prio, wr_age;
   logic          wr_est_en;
   logic [31:0]   wr_est;
   logic          wr_lr_en, wr_pa_en;

   logic [15:0]   best_ff, best_in;
   logic [SW-1:0] sel_ff, sel_in;
   logic          found_ff, found_in;
   logic [47:0]   need_ff, need_in;
   logic [35:0]   cut_ff, cut_in;

   rsp_type     out_ff, out_in;
   logic        out_v_ff, out_v_in;

   logic        div_start, div_done;
   logic [31:0] div_num, div_q;
   logic [19:0] div_den;

   apts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   function automatic logic [19:0] period_of(input cfg_type c, input logic [SW-1:0] s);
      logic [19:0] p;
      if (s == SW'(0))      p = c.period0;
      else if (s == SW'(1)) p = c.period1;
      else if (s == SW'(2)) p = c.period2;
      else                  p = c.period3;
      return (p == 20'd0) ? 20'd1 : p;
   endfunction

   function automatic logic [23:0] est_us(input logic [31:0] e);
      logic [31:0] s;
      s = e >> EST_SHIFT;
      return (s > 32'h00FF_FFFF) ? 24'hFF_FFFF : s[23:0];
   endfunction

   logic [31:0] diff;
   logic        sig_active;
   logic [15:0] cur_prio, cur_age;
   logic [32:0] age_wide;
   logic [32:0] est_grow;
   logic [32:0] g_up;
   logic signed [32:0] neg_over;

   assign guard_now = guard_ff;
   assign q_take    = (st_ff == ST_IDLE) && q_valid && !out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      st_in = st_ff; k_in = k_ff; it_in = it_ff;
      last_sig_in = last_sig_ff; guard_in = guard_ff; pend_in = pend_ff;
      best_in = best_ff; sel_in = sel_ff; found_in = found_ff;
      need_in = need_ff; cut_in = cut_ff;
      out_in = out_ff; out_v_in = out_v_ff;
      wr_slot = 1'b0; wr_idx = k_ff; wr_last_run = last_run_ff[k_ff];
      wr_prio = prio_ff[k_ff]; wr_age = age_ff[k_ff];
      wr_est_en = 1'b0; wr_est = est_ff[k_ff]; wr_lr_en = 1'b0; wr_pa_en = 1'b0;
      div_start = 1'b0; div_den = period_of(cfg, k_ff);
      sig_active = (k_ff == SigSlot) && (prio_ff[k_ff] != 16'd0);
      diff = it_ff.now_us - (sig_active ? last_sig_ff : last_run_ff[k_ff]);
      div_num = diff[31] ? 32'd0 : diff;
      cur_prio = prio_ff[k_ff]; cur_age = age_ff[k_ff];
      age_wide = '0; est_grow = '0; g_up = '0; neg_over = '0;

      if (out_v_ff && !rsp_stall) out_v_in = 1'b0;

      unique case (st_ff)
         ST_IDLE: begin
            if (q_take) begin
               it_in = q_data;
               k_in = '0; best_in = '0; sel_in = '0; found_in = 1'b0;
               if (q_data.kind == KIND_COMPLETION) begin
                  st_in = ST_DONE;
               end else if ($signed(q_data.cycles_to_deadline) >
                            $signed(32'(2 * CYCLES_PER_US))) begin
                  st_in = ST_AGE;
               end else begin
                  out_in = '0;
                  out_in.guard_margin_cycles = guard_ff;
                  out_v_in = 1'b1;
               end
            end
         end
         ST_AGE: begin
            if (k_ff == SigSlot && prio_ff[k_ff] == 16'd0) begin
               // An idle signal slot wakes only on a fresh receiver frame.
               if (it_ff.rx_ready) begin
                  last_sig_in = it_ff.now_us;
                  cur_age = 16'd1; cur_prio = 16'd2;
               end else begin
                  cur_age = 16'd0;
               end
               wr_slot = 1'b1; wr_pa_en = 1'b1; wr_age = cur_age; wr_prio = cur_prio;
               if (cur_prio > best_ff) begin
                  best_in = cur_prio; sel_in = k_ff; found_in = 1'b1;
               end
               if (k_ff == LastSlot) st_in = ST_NEED;
               else k_in = k_ff + SW'(1);
            end else begin
               div_start = 1'b1;
               st_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_done) begin
               age_wide = {1'b0, div_q} + ((k_ff == SigSlot) ? 33'd1 : 33'd0);
               cur_age = (age_wide > {17'd0, AgeMax}) ? AgeMax : age_wide[15:0];
               if (k_ff == SigSlot || cur_age != 16'd0) cur_prio = cur_age + 16'd1;
               wr_slot = 1'b1; wr_pa_en = 1'b1; wr_age = cur_age; wr_prio = cur_prio;
               if (cur_prio > best_ff) begin
                  best_in = cur_prio; sel_in = k_ff; found_in = 1'b1;
               end
               if (k_ff == LastSlot) begin
                  st_in = ST_NEED;
               end else begin
                  k_in = k_ff + SW'(1);
                  st_in = ST_AGE;
               end
            end
         end
         ST_NEED: begin
            need_in = 48'(est_ff[sel_ff] >> EST_SHIFT) * 48'(CYCLES_PER_US)
                      + 48'(guard_ff);
            cut_in = 36'(est_ff[sel_ff]) * 36'd9;
            st_in = found_ff ? ST_DECIDE : ST_DONE;
            if (!found_ff) begin
               out_in = '0;
               out_in.guard_margin_cycles = guard_ff;
               out_v_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         ST_DECIDE: begin
            out_in = '0;
            out_in.selected_slot = 2'(sel_ff);
            out_in.slot_selected = 1'b1;
            out_in.guard_margin_cycles = guard_ff;
            out_in.estimate_us = est_us(est_ff[sel_ff]);
            wr_idx = sel_ff;
            if ($signed({1'b0, need_ff}) <
                $signed({{17{it_ff.cycles_to_deadline[31]}}, it_ff.cycles_to_deadline})) begin
               out_in.run_granted = 1'b1;
               wr_slot = 1'b1; wr_lr_en = 1'b1; wr_last_run = it_ff.now_us;
               wr_pa_en = 1'b1; wr_prio = 16'd0; wr_age = age_ff[sel_ff];
               pend_in = sel_ff;
               out_v_in = 1'b1;
               st_in = ST_IDLE;
            end else if (age_ff[sel_ff] > 16'd1) begin
               out_in.expedited = 1'b1;
               st_in = ST_CUT;
            end else begin
               out_v_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         ST_CUT: begin
            // Divide by ten as a multiply by a reciprocal, exact for 36 bits.
            wr_idx = sel_ff; wr_slot = 1'b1; wr_est_en = 1'b1;
            wr_est = 32'((72'(cut_ff) * 72'd54975581389) >> 39);
            out_in.estimate_us = est_us(wr_est);
            out_v_in = 1'b1;
            st_in = ST_IDLE;
         end
         ST_DONE: begin
            wr_idx = pend_ff; wr_slot = 1'b1; wr_est_en = 1'b1;
            if (32'(it_ff.exec_time_us) > (est_ff[pend_ff] >> EST_SHIFT)) begin
               est_grow = 33'(it_ff.exec_time_us) << EST_SHIFT;
               wr_est = est_grow[32] ? 32'hFFFF_FFFF : est_grow[31:0];
            end else if (est_ff[pend_ff] > 32'd1) begin
               wr_est = est_ff[pend_ff] - 32'd1;
            end else begin
               wr_est = est_ff[pend_ff];
            end
            neg_over = -$signed({it_ff.overrun_cycles[31], it_ff.overrun_cycles});
            if ($signed(it_ff.overrun_cycles) > 0 ||
                neg_over < $signed({17'd0, cfg.guard_min})) begin
               if (guard_ff < cfg.guard_max) begin
                  g_up = 33'(guard_ff) + 33'(cfg.guard_up);
                  guard_in = (g_up > 33'hFFFF) ? 16'hFFFF : g_up[15:0];
               end
            end else if (guard_ff > cfg.guard_min) begin
               guard_in = (guard_ff > cfg.guard_down) ? guard_ff - cfg.guard_down : 16'd0;
            end
            out_in = '0;
            out_in.selected_slot = 2'(pend_ff);
            out_in.guard_margin_cycles = guard_in;
            out_in.estimate_us = est_us(wr_est);
            out_v_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         guard_ff <= cfg.guard_min;
         pend_ff <= '0;
         last_sig_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            last_run_ff[i] <= '0;
            prio_ff[i] <= '0;
            age_ff[i] <= '0;
            est_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         out_v_ff <= out_v_in;
         guard_ff <= guard_in;
         pend_ff <= pend_in;
         last_sig_ff <= last_sig_in;
         if (wr_slot) begin
            if (wr_lr_en) last_run_ff[wr_idx] <= wr_last_run;
            if (wr_pa_en) begin
               prio_ff[wr_idx] <= wr_prio;
               age_ff[wr_idx] <= wr_age;
            end
            if (wr_est_en) est_ff[wr_idx] <= wr_est;
         end
      end
      k_ff <= k_in; it_ff <= it_in; best_ff <= best_in; sel_ff <= sel_in;
      found_ff <= found_in; need_ff <= need_in; cut_ff <= cut_in; out_ff <= out_in;
   end
endmodule

>>> sv/age_priority_task_scheduler_top.sv
// Top level of the age-priority task scheduler: registers, front queue
// and back end. Depends on apts_pkg, apts_front, apts_back.
//
//   channel  direction  handshake         word
//   req_     in         req_valid/stall   apts_pkg::req_type
//   rsp_     out        rsp_valid/stall   apts_pkg::rsp_type
//   csr_     in         csr_valid/ready   index + 20-bit data
//
// A schedule request passes through the queue, then ages each slot in turn
// through the shared one-bit-per-cycle divider (an idle signal slot skips the
// divider), then picks and grants, with an extra step when the estimate is cut.
// A completion and a near deadline take shorter paths. Reset is synchronous
// and clears all slot state; the guard starts at the configured guard_min.
// Results wait in an output register under rsp_stall while the front queue
// holds two words.
module age_priority_task_scheduler_top #(
   parameter int NUM_SLOTS     = apts_pkg::NumSlotsDefault,
   parameter int CYCLES_PER_US = apts_pkg::CyclesPerUsDefault,
   parameter int EST_SHIFT     = apts_pkg::EstShiftDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  apts_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output apts_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [apts_pkg::RegIdxWidth-1:0]   csr_index,
   input  logic [19:0]                        csr_wdata
);
   import apts_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        q_valid, q_take;
   req_type     q_data;
   logic [15:0] guard_now;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PERIOD0:   cfg_in.period0 = csr_wdata;
            REG_PERIOD1:   cfg_in.period1 = csr_wdata;
            REG_PERIOD2:   cfg_in.period2 = csr_wdata;
            REG_PERIOD3:   cfg_in.period3 = csr_wdata;
            REG_GUARD_MIN: cfg_in.guard_min = csr_wdata[15:0];
            REG_GUARD_MAX: cfg_in.guard_max = csr_wdata[15:0];
            REG_GUARD_UP:  cfg_in.guard_up = csr_wdata[15:0];
            REG_GUARD_DN:  cfg_in.guard_down = csr_wdata[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period0    <= 20'd1000;
         cfg_ff.period1    <= 20'd1000;
         cfg_ff.period2    <= 20'd1000;
         cfg_ff.period3    <= 20'd10000;
         cfg_ff.guard_min  <= 16'd300;
         cfg_ff.guard_max  <= 16'd600;
         cfg_ff.guard_up   <= 16'd100;
         cfg_ff.guard_down <= 16'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   apts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_take    (q_take),
      .q_data    (q_data)
   );

   apts_back #(
      .NUM_SLOTS     (NUM_SLOTS),
      .CYCLES_PER_US (CYCLES_PER_US),
      .EST_SHIFT     (EST_SHIFT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_take    (q_take),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .guard_now (guard_now)
   );

   // The guard never leaves 16 bits and a result never reports it stale.
   a_guard_reported: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> rsp_data.guard_margin_cycles == guard_now)
      else $error("reported guard differs from current guard");

   a_grant_needs_select: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.run_granted || rsp_data.slot_selected)
      else $error("grant without a selected slot");

   a_grant_not_cut: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.run_granted && rsp_data.expedited))
      else $error("granted and expedited together");

endmodule
